// ----- hw/rtl/xsbf_pkg.sv -----
// shared types and constants of the xorshift64* byte filler
package xsbf_pkg;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned VB_W    = 3;
  localparam int unsigned CLAMP_W = 13;

  localparam logic [STATE_W-1:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0]  MULT_LO     = 32'h4F6C_DD1D;
  localparam logic [WORD_W-1:0]  MULT_HI     = 32'h2545_F491;

  localparam int unsigned SHIFT_A = 12;
  localparam int unsigned SHIFT_B = 25;
  localparam int unsigned SHIFT_C = 27;

  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  localparam logic [VB_W-1:0] VB_FULL = 3'd4;

  typedef logic [STATE_W-1:0] state_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [VB_W-1:0]   vbytes;
    logic              last;
  } res_t;

endpackage

// ----- hw/rtl/xsbf_in_if.sv -----
// request channel: fill or seed-load items
interface xsbf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [xsbf_pkg::LEN_W-1:0]    byte_length;
  logic [xsbf_pkg::STATE_W-1:0]  seed_value;

  modport source (output valid, command, byte_length, seed_value, input ready);
  modport sink   (input valid, command, byte_length, seed_value, output ready);
endinterface

// ----- hw/rtl/xsbf_out_if.sv -----
// result channel: random words with byte count and last flag
interface xsbf_out_if;
  logic                         valid;
  logic                         ready;
  logic [xsbf_pkg::WORD_W-1:0]  random_word;
  logic [xsbf_pkg::VB_W-1:0]    valid_bytes;
  logic                         last_word;

  modport source (output valid, random_word, valid_bytes, last_word, input ready);
  modport sink   (input valid, random_word, valid_bytes, last_word, output ready);
endinterface

// ----- hw/rtl/xorshift64_star_byte_filler_top.sv -----
// top level of the xorshift64* byte filler
//
//   channel   dir   handshake            payload
//   in_if     in    valid / ready        command, byte_length, seed_value
//   out_if    out   valid / ready        random_word, valid_bytes, last_word
//
// a seed load is taken in the idle state; a fill of n bytes yields ceil(n / 4) words
// each word takes an xorshift step, three passes through the single 32x32
// multiplier, an accumulate and a hand-off
// rst_n is synchronous; the generator state resets to zero
// a stalled output holds the sequencer in its hand-off cycle; in_if.ready is low
// while a fill is running
module xorshift64_star_byte_filler_top #(
  parameter int unsigned MAX_REQUEST_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  xsbf_in_if.sink     in_if,
  xsbf_out_if.source  out_if
);
  import xsbf_pkg::*;

  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] mul_prod;
  logic                res_push, res_rdy;
  res_t                res;

  logic                out_valid_r;
  res_t                out_res_r;

  xsbf_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_prod)
  );

  xsbf_ctrl #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_prod (mul_prod),
    .res_push (res_push),
    .res      (res),
    .res_rdy  (res_rdy)
  );

  // output register takes a new item when empty or being drained
  assign res_rdy = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.random_word = out_res_r.word;
  assign out_if.valid_bytes = out_res_r.vbytes;
  assign out_if.last_word   = out_res_r.last;

endmodule

// ----- hw/rtl/xsbf_mul.sv -----
// shared 32x32 multiplier with registered product
module xsbf_mul (
  input  logic                                clk,
  input  logic [xsbf_pkg::WORD_W-1:0]         op_a,
  input  logic [xsbf_pkg::WORD_W-1:0]         op_b,
  output logic [2*xsbf_pkg::WORD_W-1:0]       prod_r
);
  import xsbf_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ----- hw/rtl/xsbf_ctrl.sv -----
// sequencer: generator state, xorshift step and partial-product accumulation
module xsbf_ctrl #(
  parameter int unsigned MAX_REQUEST_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  xsbf_in_if.sink                        in_if,
  output logic [xsbf_pkg::WORD_W-1:0]    mul_a,
  output logic [xsbf_pkg::WORD_W-1:0]    mul_b,
  input  logic [2*xsbf_pkg::WORD_W-1:0]  mul_prod,
  output logic                           res_push,
  output xsbf_pkg::res_t                 res,
  input  logic                           res_rdy
);
  import xsbf_pkg::*;

  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned CAP = (MAX_REQUEST_BYTES < LEN_MAX) ? MAX_REQUEST_BYTES : LEN_MAX;
  localparam int unsigned LW  = $clog2(CAP + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_MUL0, S_MUL1, S_MUL2, S_ACC, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  state_word_t       gen_r, gen_nxt;
  logic [LW-1:0]     rem_r, rem_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;

  logic              in_acc;
  logic [CLAMP_W-1:0] len_ext, len_clamp;
  state_word_t       xs0, xs1, xs2, xs3;
  logic [VB_W-1:0]   vb;
  logic [WORD_W-1:0] word_masked;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  assign len_ext   = {{(CLAMP_W-LEN_W){1'b0}}, in_if.byte_length};
  assign len_clamp = (len_ext > CLAMP_W'(MAX_REQUEST_BYTES)) ? CLAMP_W'(MAX_REQUEST_BYTES)
                                                             : len_ext;

  // zero state is swapped for the golden seed before stepping
  assign xs0 = (gen_r == '0) ? GOLDEN_SEED : gen_r;
  assign xs1 = xs0 ^ (xs0 >> SHIFT_A);
  assign xs2 = xs1 ^ (xs1 << SHIFT_B);
  assign xs3 = xs2 ^ (xs2 >> SHIFT_C);

  // high half of the low 64 product bits: lo*lo high + lo*hi low + hi*lo low
  assign mul_a = (state_r == S_MUL2) ? gen_r[STATE_W-1:WORD_W] : gen_r[WORD_W-1:0];
  assign mul_b = (state_r == S_MUL1) ? MULT_HI : MULT_LO;

  assign vb = (rem_r >= LW'(4)) ? VB_FULL : {1'b0, rem_r[1:0]};

  always_comb begin
    case (vb)
      3'd1:    word_masked = {24'd0, acc_r[7:0]};
      3'd2:    word_masked = {16'd0, acc_r[15:0]};
      3'd3:    word_masked = {8'd0, acc_r[23:0]};
      default: word_masked = acc_r;
    endcase
  end

  assign res_push   = (state_r == S_EMIT) && res_rdy;
  assign res.word   = word_masked;
  assign res.vbytes = vb;
  assign res.last   = (rem_r <= LW'(4));

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_if.command == CMD_SEED) begin
            gen_nxt = in_if.seed_value;
          end else if (len_clamp != '0) begin
            rem_nxt   = len_clamp[LW-1:0];
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        gen_nxt   = xs3;
        state_nxt = S_MUL0;
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: begin
        acc_nxt   = mul_prod[2*WORD_W-1:WORD_W];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = acc_r + mul_prod[WORD_W-1:0];
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = acc_r + mul_prod[WORD_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_rdy) begin
          rem_nxt   = rem_r - LW'(vb);
          state_nxt = res.last ? S_IDLE : S_SHIFT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gen_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      rem_r   <= rem_nxt;
    end
    acc_r <= acc_nxt;
  end

  a_seed_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_if.command == CMD_SEED |=> gen_r == $past(in_if.seed_value))
    else $error("seed load did not reach generator state");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.last |=> in_if.ready)
    else $error("block not ready after last word of a fill");

  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> rem_r != '0)
    else $error("busy with no bytes left");

  a_partial_mask: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.vbytes != VB_FULL |-> res.last && res.word[WORD_W-1:24] == '0)
    else $error("partial word not last or not masked");

endmodule

// ----- dv/xsbf_checker.sv -----
// predicts and checks the result words of the xorshift64* byte filler
`timescale 1ns / 1ps

module xsbf_checker
  import xsbf_pkg::*;
#(
  parameter int unsigned MAX_REQUEST_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  xsbf_in_if         in_mon,
  xsbf_out_if        out_mon,
  output int         fail_count,
  output int         pending
);

  localparam logic [STATE_W-1:0] STAR_MULT = {MULT_HI, MULT_LO};
  localparam int MAX_REPORTS = 10;

  state_word_t gen_state;
  res_t        expected_words[$];

  // advance the generator one step and return the high half of the product
  function automatic logic [WORD_W-1:0] next_draw();
    state_word_t s;
    state_word_t prod;
    s = (gen_state == '0) ? GOLDEN_SEED : gen_state;
    s = s ^ (s >> SHIFT_A);
    s = s ^ (s << SHIFT_B);
    s = s ^ (s >> SHIFT_C);
    gen_state = s;
    prod = s * STAR_MULT;
    return prod[STATE_W-1:WORD_W];
  endfunction

  function automatic void predict_fill(input logic [LEN_W-1:0] len_in);
    int unsigned len;
    int unsigned whole;
    int unsigned part;
    res_t        r;
    logic [WORD_W-1:0] mask;
    len = len_in;
    if (len > MAX_REQUEST_BYTES) len = MAX_REQUEST_BYTES;
    whole = len / 4;
    part  = len % 4;
    for (int unsigned k = 0; k < whole; k++) begin
      r.word   = next_draw();
      r.vbytes = VB_FULL;
      r.last   = (part == 0) && (k + 1 == whole);
      expected_words.push_back(r);
    end
    if (part != 0) begin
      mask     = (32'h1 << (8 * part)) - 32'h1;
      r.word   = next_draw() & mask;
      r.vbytes = VB_W'(part);
      r.last   = 1'b1;
      expected_words.push_back(r);
    end
  endfunction

  initial begin
    fail_count = 0;
    gen_state  = '0;
  end

  assign pending = expected_words.size();

  always @(posedge clk) begin
    res_t exp_w;
    if (!rst_n) begin
      gen_state = '0;
      expected_words.delete();
    end else begin
      // compare before predicting, so a word can never meet its own item
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected word %h vb %0d last %b", $realtime,
                     out_mon.random_word, out_mon.valid_bytes, out_mon.last_word);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_mon.random_word !== exp_w.word || out_mon.valid_bytes !== exp_w.vbytes ||
              out_mon.last_word !== exp_w.last) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: word mismatch: exp %h vb %0d last %b, got %h vb %0d last %b",
                       $realtime, exp_w.word, exp_w.vbytes, exp_w.last,
                       out_mon.random_word, out_mon.valid_bytes, out_mon.last_word);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_SEED) gen_state = in_mon.seed_value;
        else predict_fill(in_mon.byte_length);
      end
    end
  end

endmodule

// ----- dv/tb_xorshift64_star_byte_filler_top.sv -----
// stimulus and verdict for the xorshift64* byte filler
`timescale 1ns / 1ps

module tb_xorshift64_star_byte_filler_top;
  import xsbf_pkg::*;

  localparam int unsigned MAX_BYTES   = 256;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          RANDOM_ITEMS = 150;
  localparam int          DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  logic calm_in;
  logic calm_out;

  xsbf_in_if  in_ch();
  xsbf_out_if out_ch();

  xorshift64_star_byte_filler_top #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  xsbf_checker #(
    .MAX_REQUEST_BYTES(MAX_BYTES)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall before each word, with calm stretches
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    calm_out = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = ~calm_out;
      gap = calm_out ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // entered just after reset or just after an accepting edge
  task automatic send_item(input logic cmd, input logic [LEN_W-1:0] len,
                           input state_word_t seed);
    int gap;
    if ($urandom_range(0, 15) == 0) calm_in = ~calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.byte_length <= len;
    in_ch.seed_value  <= seed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic state_word_t rand_seed();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int unsigned r;
    logic [LEN_W-1:0] len;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_FILL;
    in_ch.byte_length = '0;
    in_ch.seed_value  = '0;
    calm_in = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-length fill leaves the zero state, next draw replaces it
    send_item(CMD_FILL, 9'd0, rand_seed());
    send_item(CMD_FILL, 9'd1, '1);
    send_item(CMD_FILL, 9'd2, '0);
    send_item(CMD_FILL, 9'd3, rand_seed());
    send_item(CMD_FILL, 9'd4, rand_seed());
    send_item(CMD_FILL, 9'd5, rand_seed());
    // zero seed is kept until the next draw, length is ignored on a load
    send_item(CMD_SEED, 9'h1ff, '0);
    send_item(CMD_FILL, 9'd7, rand_seed());
    send_item(CMD_SEED, 9'd0, '1);
    send_item(CMD_FILL, 9'd256, '0);
    // oversized lengths saturate
    send_item(CMD_FILL, 9'd257, rand_seed());
    send_item(CMD_FILL, 9'h1ff, '1);
    send_item(CMD_SEED, 9'd13, 64'd1);
    send_item(CMD_FILL, 9'd8, rand_seed());
    send_item(CMD_FILL, 9'd0, rand_seed());
    send_item(CMD_SEED, 9'h0aa, rand_seed());
    send_item(CMD_FILL, 9'd255, rand_seed());
    send_item(CMD_FILL, 9'd6, rand_seed());
    send_item(CMD_SEED, 9'h155, 64'h8000_0000_0000_0000);
    send_item(CMD_FILL, 9'd9, rand_seed());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_item(CMD_SEED, LEN_W'($urandom),
                  ($urandom_range(0, 7) == 0) ? state_word_t'(0) : rand_seed());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6)       len = LEN_W'($urandom_range(257, 511));
        else if (r < 12) len = LEN_W'($urandom_range(100, 256));
        else if (r < 18) len = '0;
        else             len = LEN_W'($urandom_range(1, 40));
        send_item(CMD_FILL, len, rand_seed());
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
